// ===== sv/rnsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rnsp_pkg: shared types and constants of the radix number string parser
// Character codes, status codes, counter width and the result entry type.
// ----------------------------------------------------------------------------
package rnsp_pkg;

  // width of the character and digit counters inside the core
  localparam int unsigned CountW = 16;

  // width of the count fields on the result port
  localparam int unsigned OutCountW = 16;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] CaseBit = 8'h20;

  // radix limits and reset value
  localparam logic [5:0] RadixMin   = 6'd2;
  localparam logic [5:0] RadixMax   = 6'd36;
  localparam logic [5:0] RadixReset = 6'd10;
  localparam logic [5:0] LetterBase = 6'd10;

  // register indexes of the configuration port
  localparam logic [0:0] RegRadix = 1'b0;

  // summary status codes
  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StLeadUnder  = 2'd1,
    StNoDigits   = 2'd2,
    StTrailUnder = 2'd3
  } status_e;

  // one queued entry: a digit beat, a summary beat, or a digit then a summary
  typedef struct packed {
    logic                  has_digit;
    logic                  has_final;
    logic [6:0]            digit_char;
    logic                  negative;
    status_e               status;
    logic [OutCountW-1:0]  consumed;
    logic [OutCountW-1:0]  digits;
  } entry_t;

  // saturating increment of a counter
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = (&v) ? v : CountW'(v + 1'b1);
    return r;
  endfunction

endpackage

// ===== sv/radix_number_string_parser_core.sv =====
// ----------------------------------------------------------------------------
// radix_number_string_parser_core: streaming signed number parser
// Takes one ASCII character a beat, parses signs, leading zeros, separators
// and digits in a set radix, and emits digit beats and a parse summary.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake                     payload
//  ----------   ---------  ----------------------------  ----------------------
//  input        in         in_valid_i / in_ready_o       char_in_i
//  result       out        out_valid_o / out_ready_i     is_final_o .. last_result_o
//  config       in/out     psel, penable, pready         paddr, pwdata, prdata
//
//  one character is taken per cycle; a beat lands in an input register and is
//  parsed in the next cycle, its results entering a four-entry result queue
//  most characters give one beat or none; a NUL right after leading zeros gives
//  two, so the result port (one beat a cycle) sets the rate for those strings
//  in_ready_o drops only when the queue plus the character in flight fill it
//  reset clears the parse state and the queue, and sets the radix to ten

module radix_number_string_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // character input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_in_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_final_o,
  output logic [6:0]                    digit_char_o,
  output logic                          negative_o,
  output logic [1:0]                    status_o,
  output logic [15:0]                   consumed_count_o,
  output logic [15:0]                   digit_count_o,
  output logic                          last_result_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rnsp_pkg::*;

  typedef enum logic [1:0] {
    PhSign  = 2'd0,
    PhZero  = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // configuration register
  logic [5:0] radix_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_wr && (paddr[2] == RegRadix)) begin
      radix_q <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == RegRadix) ? {26'd0, radix_q} : 32'd0;

  // input register
  logic       in_fire;
  logic       in_valid_q;
  logic [7:0] char_q;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_in_i;
    end
  end

  // character classes
  logic       is_dec, is_up, is_lo, is_sign, is_under, is_zch, is_nul;
  logic [5:0] sym_val, eff_radix;
  logic       dig_ok;
  logic [6:0] norm_char;

  always_comb begin
    is_dec   = (char_q >= ChZero) && (char_q <= ChNine);
    is_up    = (char_q >= ChUpA) && (char_q <= ChUpZ);
    is_lo    = (char_q >= ChLoA) && (char_q <= ChLoZ);
    is_sign  = (char_q == ChMinus) || (char_q == ChPlus);
    is_under = (char_q == ChUnder);
    is_zch   = (char_q == ChZero);
    is_nul   = (char_q == ChNul);
    if (is_dec) begin
      sym_val = 6'(char_q - ChZero);
    end else if (is_up) begin
      sym_val = 6'(char_q - ChUpA) + LetterBase;
    end else begin
      sym_val = 6'(char_q - ChLoA) + LetterBase;
    end
    if (radix_q < RadixMin) begin
      eff_radix = RadixMin;
    end else if (radix_q > RadixMax) begin
      eff_radix = RadixMax;
    end else begin
      eff_radix = radix_q;
    end
    dig_ok    = (is_dec || is_up || is_lo) && (sym_val < eff_radix);
    norm_char = is_lo ? 7'(char_q & ~CaseBit) : char_q[6:0];
  end

  // parse state
  phase_e            phase_q, phase_d;
  logic              sign_q, sign_d;
  logic              zeros_q, zeros_d;
  logic              under_q, under_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] dig_q, dig_d;
  entry_t            ent;
  logic              push;

  // parse step for the registered character
  always_comb begin
    logic              in_sign_ph;
    logic [CountW-1:0] cnt_inc;
    logic [CountW-1:0] dig_inc;
    in_sign_ph = !((phase_q == PhZero) || (phase_q == PhDigit));
    cnt_inc    = sat_inc(cnt_q);
    dig_inc    = sat_inc(dig_q);
    phase_d    = phase_q;
    sign_d     = sign_q;
    zeros_d    = zeros_q;
    under_d    = under_q;
    cnt_d      = cnt_q;
    dig_d      = dig_q;
    push       = 1'b0;
    ent.has_digit  = 1'b0;
    ent.has_final  = 1'b0;
    ent.digit_char = norm_char;
    ent.negative   = sign_q;
    ent.status     = StOk;
    ent.consumed   = OutCountW'(cnt_q);
    ent.digits     = OutCountW'(dig_q);
    if (in_valid_q) begin
      if (in_sign_ph && is_sign) begin
        // sign run, each minus flips the sign
        if (char_q == ChMinus) begin
          sign_d = !sign_q;
        end
        cnt_d   = cnt_inc;
        phase_d = PhSign;
      end else if (in_sign_ph && is_under) begin
        // underscore at the start or right after the signs
        push          = 1'b1;
        ent.has_final = 1'b1;
        ent.status    = StLeadUnder;
        ent.digits    = '0;
      end else if ((phase_q != PhDigit) && is_zch) begin
        // leading zero, dropped
        zeros_d = 1'b1;
        cnt_d   = cnt_inc;
        phase_d = PhZero;
      end else if ((phase_q != PhDigit) && is_nul && zeros_q) begin
        // string of zeros only: keep one zero, then summary
        push           = 1'b1;
        ent.has_digit  = 1'b1;
        ent.has_final  = 1'b1;
        ent.digit_char = ChZero[6:0];
        ent.digits     = OutCountW'(dig_inc);
      end else if (is_under) begin
        // separator
        phase_d = PhDigit;
        under_d = 1'b1;
        cnt_d   = cnt_inc;
      end else if (dig_ok) begin
        // digit beat
        phase_d       = PhDigit;
        under_d       = 1'b0;
        cnt_d         = cnt_inc;
        dig_d         = dig_inc;
        push          = 1'b1;
        ent.has_digit = 1'b1;
        ent.consumed  = OutCountW'(cnt_inc);
        ent.digits    = OutCountW'(dig_inc);
      end else begin
        // terminator: summary
        push          = 1'b1;
        ent.has_final = 1'b1;
        if (dig_q == '0) begin
          ent.status = StNoDigits;
        end else if (under_q) begin
          ent.status = StTrailUnder;
          if (cnt_q != '0) begin
            ent.consumed = OutCountW'(cnt_q - 1'b1);
          end
        end else begin
          ent.status = StOk;
        end
      end
      // a summary ends the number and clears the parse state
      if (push && ent.has_final) begin
        phase_d = PhSign;
        sign_d  = 1'b0;
        zeros_d = 1'b0;
        under_d = 1'b0;
        cnt_d   = '0;
        dig_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSign;
      sign_q  <= 1'b0;
      zeros_q <= 1'b0;
      under_q <= 1'b0;
      cnt_q   <= '0;
      dig_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sign_q  <= sign_d;
      zeros_q <= zeros_d;
      under_q <= under_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
    end
  end

  // result queue
  entry_t            q_mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  q_cnt_q;
  logic              sub_q;
  logic              out_fire, pop;
  entry_t            head;
  logic              digit_beat;

  assign head       = q_mem[rd_ptr_q];
  assign out_valid_o = (q_cnt_q != '0);
  assign out_fire   = out_valid_o && out_ready_i;
  assign digit_beat = head.has_digit && !sub_q;
  assign pop        = out_fire && !(digit_beat && head.has_final);

  // room for the character in flight and one more
  assign in_ready_o = ((QCntW + 1)'(q_cnt_q) + (QCntW + 1)'(in_valid_q))
                      < (QCntW + 1)'(QDepth);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   q_cnt_q <= q_cnt_q + 1'b1;
        2'b01:   q_cnt_q <= q_cnt_q - 1'b1;
        default: q_cnt_q <= q_cnt_q;
      endcase
      if (pop) begin
        sub_q <= 1'b0;
      end else if (out_fire) begin
        sub_q <= 1'b1;
      end
    end
  end

  // result beat from the queue head
  assign is_final_o       = !digit_beat;
  assign digit_char_o     = digit_beat ? head.digit_char : 7'd0;
  assign negative_o       = head.negative;
  assign status_o         = digit_beat ? StOk : head.status;
  assign consumed_count_o = head.consumed;
  assign digit_count_o    = head.digits;
  assign last_result_o    = !(digit_beat && head.has_final);

  // checks
  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni)
      push |-> (q_cnt_q < QCntW'(QDepth)) || pop;
  endproperty
  assert property (p_no_overflow)
    else $error("result queue written while full");

  property p_sub_on_pair;
    @(posedge clk_i) disable iff (!rst_ni)
      sub_q |-> (out_valid_o && head.has_digit && head.has_final);
  endproperty
  assert property (p_sub_on_pair)
    else $error("second beat pending on an entry without a digit and a summary");

  property p_summary_follows;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_fire && !last_result_o) |=> (out_valid_o && is_final_o);
  endproperty
  assert property (p_summary_follows)
    else $error("summary missing after a non-last digit beat");

  property p_clear_after_summary;
    @(posedge clk_i) disable iff (!rst_ni)
      (push && ent.has_final) |=> (phase_q == PhSign) && (cnt_q == '0) && (dig_q == '0);
  endproperty
  assert property (p_clear_after_summary)
    else $error("parse state not cleared after a summary");

endmodule
